// ===== sv/dfp_pkg.sv =====
// dfp_pkg: shared types and constants for the download frame parser
// frame byte codes, parse phases, status codes and the result word layout
// no dependencies
`default_nettype none

package dfp_pkg;

	localparam int unsigned MAX_PAYLOAD = 1024;
	localparam int unsigned REMAIN_W    = 11;

	localparam logic [7:0] START_BYTE = 8'h88;
	localparam logic [7:0] TAIL_BYTE  = 8'h66;
	localparam logic [7:0] CMD_INFO   = 8'h01;
	localparam logic [7:0] CMD_DATA   = 8'h02;

	localparam logic [31:0] MAX_PAYLOAD_W = 32'(MAX_PAYLOAD);

	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 80;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_CMD  = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_BAD_SUM  = 3'd3,
		ST_BAD_TAIL = 3'd4
	} status_t;

	typedef enum logic [7:0] {
		PH_HUNT    = 8'b0000_0001,
		PH_CMD     = 8'b0000_0010,
		PH_ADDR    = 8'b0000_0100,
		PH_LEN     = 8'b0000_1000,
		PH_PAYLOAD = 8'b0001_0000,
		PH_SUM_LO  = 8'b0010_0000,
		PH_SUM_HI  = 8'b0100_0000,
		PH_TAIL    = 8'b1000_0000
	} phase_t;

	// one received word after the input register
	typedef struct packed {
		logic       buffer_start;
		logic [7:0] rx_byte;
	} in_item_t;

	// one result word
	typedef struct packed {
		logic        frame_end;
		logic [7:0]  payload_byte;
		logic        frame_kind;
		logic [31:0] frame_address;
		logic [31:0] frame_length;
		logic [2:0]  frame_status;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/download_frame_parser.sv =====
// download_frame_parser: top level of the download frame parser
// wires the input register, the parse core and the result register; uses dfp_pkg
`default_nettype none

// usage
//   slave side: one received byte per word on s_axis_tdata[7:0]; s_axis_tuser
//   set forces that byte to be taken as the first byte of a new frame
//   master side: one result word per payload byte (m_axis_tuser low, byte in
//   tdata[7:0]) and one end-of-frame word per frame (m_axis_tuser high) with
//   kind, address, length and status; bytes seen while hunting give no word,
//   nor does a frame cut off by a new s_axis_tuser byte; a byte is taken
//   into the input register, then passes through the parse logic into the
//   result register, from which the receiver takes its word
//   throughput: one byte per cycle while m_axis_tready stays high, with a
//   single parse step between the input register and the result register
//   reset (arst_n low) empties both registers and puts the parser into
//   hunting for the start byte with all frame fields cleared
//   stall: when the receiver holds m_axis_tready low with a word waiting,
//   the parser stops, the input register keeps one byte and s_axis_tready
//   drops once that register is full; nothing is lost or repeated
module download_frame_parser (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [dfp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
	input  wire                              s_axis_tuser,  // [0] buffer_start
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// [7:0] payload_byte, [8] frame_kind, [40:9] frame_address,
	// [72:41] frame_length, [75:73] frame_status, [79:76] zero
	output logic [dfp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tuser   // [0] frame_end
);
	import dfp_pkg::*;

	logic     item_valid;
	in_item_t item;
	logic     out_free;
	logic     advance;
	logic     res_valid;
	result_t  res;

	// the held byte is parsed whenever the result register can take a word
	assign advance = item_valid && out_free;

	dfp_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.take          (advance),
		.item_valid    (item_valid),
		.item          (item)
	);

	dfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	// load only on a parse step that produced a word
	dfp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && res_valid),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ===== sv/dfp_in_stage.sv =====
// dfp_in_stage: input register of the download frame parser
// holds one received word until the parser core takes it; uses dfp_pkg
`default_nettype none

module dfp_in_stage (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [dfp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  wire                              s_axis_tuser,
	input  wire                              take,
	output logic                             item_valid,
	output dfp_pkg::in_item_t                item
);
	import dfp_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	// room when empty or when the held word leaves this cycle
	assign s_axis_tready = !valid_s1 || take;
	assign item_valid    = valid_s1;
	assign item          = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.rx_byte      <= s_axis_tdata[7:0];
			item_s1.buffer_start <= s_axis_tuser;
		end
	end

endmodule

`default_nettype wire

// ===== sv/dfp_core.sv =====
// dfp_core: frame parse state and per-word result logic
// one word is consumed per step; uses dfp_pkg
`default_nettype none

module dfp_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                step,
	input  dfp_pkg::in_item_t  item,
	output logic               res_valid,
	output dfp_pkg::result_t   res
);
	import dfp_pkg::*;

	phase_t               phase_q, phase_d;
	logic [1:0]           idx_q, idx_d;
	logic                 cmd_q, cmd_d;
	logic [31:0]          addr_q, addr_d;
	logic [31:0]          len_q, len_d;
	logic [REMAIN_W-1:0]  remain_q, remain_d;
	logic [15:0]          sum_q, sum_d;
	logic [7:0]           sum_lo_q, sum_lo_d;

	logic [7:0]  b;
	logic [15:0] sum_add;
	logic [31:0] len_full;

	assign b        = item.rx_byte;
	assign sum_add  = sum_q + {8'h00, b};
	assign len_full = {b, len_q[23:0]};

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		cmd_d     = cmd_q;
		addr_d    = addr_q;
		len_d     = len_q;
		remain_d  = remain_q;
		sum_d     = sum_q;
		sum_lo_d  = sum_lo_q;
		res_valid = 1'b0;
		res       = '0;

		if (step) begin
			if (item.buffer_start || phase_q == PH_HUNT) begin
				// drop frame in progress, look for a start byte
				idx_d    = '0;
				cmd_d    = 1'b0;
				addr_d   = '0;
				len_d    = '0;
				remain_d = '0;
				sum_d    = '0;
				sum_lo_d = '0;
				phase_d  = (b == START_BYTE) ? PH_CMD : PH_HUNT;
			end else begin
				case (phase_q)
					PH_CMD: begin
						sum_d = {8'h00, b};
						idx_d = '0;
						if (b == CMD_INFO) begin
							cmd_d   = 1'b0;
							phase_d = PH_ADDR;
						end else if (b == CMD_DATA) begin
							cmd_d   = 1'b1;
							phase_d = PH_ADDR;
						end else begin
							cmd_d               = 1'b0;
							addr_d              = '0;
							len_d               = '0;
							res_valid           = 1'b1;
							res.frame_end       = 1'b1;
							res.frame_status    = ST_BAD_CMD;
							phase_d             = PH_HUNT;
						end
					end
					PH_ADDR: begin
						sum_d = sum_add;
						// info frames keep the address at zero
						if (cmd_q) begin
							addr_d[idx_q*8 +: 8] = b;
						end
						if (idx_q == 2'd3) begin
							phase_d = PH_LEN;
						end
						idx_d = idx_q + 2'd1;
					end
					PH_LEN: begin
						sum_d               = sum_add;
						len_d[idx_q*8 +: 8] = b;
						idx_d               = idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							if (cmd_q) begin
								if (len_full > MAX_PAYLOAD_W) begin
									res_valid         = 1'b1;
									res.frame_end     = 1'b1;
									res.frame_kind    = cmd_q;
									res.frame_address = addr_q;
									res.frame_length  = len_full;
									res.frame_status  = ST_TOO_LONG;
									phase_d           = PH_HUNT;
								end else begin
									remain_d = len_full[REMAIN_W-1:0];
									phase_d  = (len_full[REMAIN_W-1:0] == '0)
										? PH_SUM_LO : PH_PAYLOAD;
								end
							end else begin
								phase_d = PH_SUM_LO;
							end
						end
					end
					PH_PAYLOAD: begin
						sum_d            = sum_add;
						remain_d         = remain_q - REMAIN_W'(1);
						if (remain_q == REMAIN_W'(1)) begin
							phase_d = PH_SUM_LO;
						end
						res_valid        = 1'b1;
						res.frame_end    = 1'b0;
						res.payload_byte = b;
					end
					PH_SUM_LO: begin
						sum_lo_d = b;
						phase_d  = PH_SUM_HI;
					end
					PH_SUM_HI: begin
						if ({b, sum_lo_q} != sum_q) begin
							res_valid         = 1'b1;
							res.frame_end     = 1'b1;
							res.frame_kind    = cmd_q;
							res.frame_address = addr_q;
							res.frame_length  = len_q;
							res.frame_status  = ST_BAD_SUM;
							phase_d           = PH_HUNT;
						end else begin
							phase_d = PH_TAIL;
						end
					end
					PH_TAIL: begin
						res_valid         = 1'b1;
						res.frame_end     = 1'b1;
						res.frame_kind    = cmd_q;
						res.frame_address = addr_q;
						res.frame_length  = len_q;
						res.frame_status  = (b == TAIL_BYTE) ? ST_OK : ST_BAD_TAIL;
						phase_d           = PH_HUNT;
					end
					default: begin
						phase_d  = PH_HUNT;
						idx_d    = '0;
						cmd_d    = 1'b0;
						addr_d   = '0;
						len_d    = '0;
						remain_d = '0;
						sum_d    = '0;
						sum_lo_d = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			idx_q    <= '0;
			cmd_q    <= 1'b0;
			addr_q   <= '0;
			len_q    <= '0;
			remain_q <= '0;
			sum_q    <= '0;
			sum_lo_q <= '0;
		end else begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			cmd_q    <= cmd_d;
			addr_q   <= addr_d;
			len_q    <= len_d;
			remain_q <= remain_d;
			sum_q    <= sum_d;
			sum_lo_q <= sum_lo_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/dfp_out_reg.sv =====
// dfp_out_reg: result register of the download frame parser
// holds one result word for the receiver; uses dfp_pkg
`default_nettype none

module dfp_out_reg (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              load,
	input  dfp_pkg::result_t                 res,
	output logic                             free,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [dfp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tuser
);
	import dfp_pkg::*;

	logic    valid_q;
	result_t res_q;

	// empty, or the held word is taken this cycle
	assign free          = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = res_q.frame_end;
	assign m_axis_tdata  = {4'h0, res_q.frame_status, res_q.frame_length,
		res_q.frame_address, res_q.frame_kind, res_q.payload_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire
